// ----- hdl/tftp_transfer_engine_macros.svh -----
// Assertion helpers shared by the transfer engine RTL
`ifndef TFTP_TRANSFER_ENGINE_MACROS_SVH
`define TFTP_TRANSFER_ENGINE_MACROS_SVH

// Same-cycle implication, masked during reset
`define TTE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset
`define TTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/tte_pkg.sv -----
`default_nettype none

package tte_pkg;

    // Fixed protocol sizes
    localparam logic [9:0] BLOCK_BYTES  = 10'd512;
    localparam logic [9:0] HEADER_BYTES = 10'd4;
    localparam logic [9:0] MAX_PKT_LEN  = 10'd516;

    // Event kinds
    localparam logic [1:0] FUNC_START_READ  = 2'd0;
    localparam logic [1:0] FUNC_START_WRITE = 2'd1;
    localparam logic [1:0] FUNC_PACKET      = 2'd2;
    localparam logic [1:0] FUNC_TIMEOUT     = 2'd3;

    // TFTP opcodes
    localparam logic [15:0] OP_DATA  = 16'd3;
    localparam logic [15:0] OP_ACK   = 16'd4;
    localparam logic [15:0] OP_ERROR = 16'd5;

    // Result commands
    localparam logic [2:0] ACT_SEND_DATA    = 3'd0;
    localparam logic [2:0] ACT_SEND_ACK     = 3'd1;
    localparam logic [2:0] ACT_SEND_ERR     = 3'd2;
    localparam logic [2:0] ACT_STORE        = 3'd3;
    localparam logic [2:0] ACT_DONE         = 3'd4;
    localparam logic [2:0] ACT_FAIL_TIMEOUT = 3'd5;
    localparam logic [2:0] ACT_FAIL_PEER    = 3'd6;
    localparam logic [2:0] ACT_FAIL_INVALID = 3'd7;

    // Error codes carried by a send error
    localparam logic EC_INVALID = 1'b0;
    localparam logic EC_BAD_TID = 1'b1;

    localparam logic [7:0] RETRY_LIMIT_RST = 8'd5;

    // One incoming event
    typedef struct packed {
        logic [1:0]  func;
        logic        from_expected_peer;
        logic [9:0]  pkt_len;
        logic [15:0] opcode;
        logic [15:0] block_num;
        logic [9:0]  next_len;
    } t_evt;

    // Compressed results of one event; cnt is 0 when nothing is produced
    typedef struct packed {
        logic [2:0]  act;
        logic [15:0] block;
        logic [9:0]  length;
        logic        error_code;
        logic [1:0]  cnt;
    } t_rec;

endpackage

`default_nettype wire

// ----- hdl/tftp_transfer_engine.sv -----
`default_nettype none

// Stop-and-wait TFTP session controller. Each event (start read, start
// write, packet received, receive timeout) is taken into an input register,
// decided against the session state into a record register, and expanded
// into one to three commands that leave through a registered output
// stream, one per cycle while tready is high. A new event can be taken
// every cycle while the command stage is free; an event holds the output
// until all its commands (three in the store-ack-done case of a write) are
// taken. Events that yield nothing leave no record behind.
// The retry limit register may be written only while no event is in flight.
module tftp_transfer_engine (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // event stream
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [0] from_expected_peer, [10:1] pkt_len, [26:11] opcode,
    // [42:27] block_num, [52:43] next_len, [55:53] zero
    input  wire  [55:0] i_s_axis_tdata,
    // [1:0] func
    input  wire  [1:0]  i_s_axis_tuser,
    // command stream
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // [2:0] action, [18:3] block, [28:19] length, [29] error_code, [31:30] zero
    output logic [31:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast,
    // retry limit register
    input  wire         i_cfg_we,
    input  wire  [7:0]  i_cfg_wdata
);

    logic [7:0]     r_retry_limit;

    tte_pkg::t_evt  r_a_evt;
    logic           r_a_v;
    tte_pkg::t_rec  rec;
    tte_pkg::t_rec  r_b;
    logic           r_b_v;
    logic [1:0]     r_idx;
    logic           r_o_v;
    logic [31:0]    r_o_data;
    logic           r_o_last;

    logic           a_move;
    logic           o_load;
    logic           b_pop;
    logic           k_last;
    logic [2:0]     k_act;
    logic [15:0]    k_blk;
    logic [9:0]     k_len;
    logic           k_ec;

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit <= tte_pkg::RETRY_LIMIT_RST;
        end else if (i_cfg_we) begin
            r_retry_limit <= i_cfg_wdata;
        end
    end

    // Handshake flow
    assign o_load          = r_b_v && (!r_o_v || i_m_axis_tready);
    assign k_last          = (r_idx == (r_b.cnt - 2'd1));
    assign b_pop           = o_load && k_last;
    assign a_move          = r_a_v && (!r_b_v || b_pop);
    assign o_s_axis_tready = !r_a_v || a_move;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_a_v <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_a_evt.func               <= i_s_axis_tuser;
            r_a_evt.from_expected_peer <= i_s_axis_tdata[0];
            r_a_evt.pkt_len            <= i_s_axis_tdata[10:1];
            r_a_evt.opcode             <= i_s_axis_tdata[26:11];
            r_a_evt.block_num          <= i_s_axis_tdata[42:27];
            r_a_evt.next_len           <= i_s_axis_tdata[52:43];
        end
    end

    tte_session u_session (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ev_valid   (a_move),
        .i_ev         (r_a_evt),
        .i_retry_limit(r_retry_limit),
        .o_rec        (rec)
    );

    // Result record register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
            r_idx <= 2'd0;
        end else if (a_move) begin
            r_b_v <= (rec.cnt != 2'd0);
            r_idx <= 2'd0;
        end else if (b_pop) begin
            r_b_v <= 1'b0;
            r_idx <= 2'd0;
        end else if (o_load) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_b <= rec;
        end
    end

    // Expand the record into its k-th command
    always_comb begin
        k_act = r_b.act;
        k_blk = r_b.block;
        k_len = r_b.length;
        k_ec  = r_b.error_code;
        if (r_idx != 2'd0) begin
            k_blk = 16'd0;
            k_len = 10'd0;
            k_ec  = 1'b0;
            case (r_b.act)
                tte_pkg::ACT_STORE: begin
                    if (r_idx == 2'd1) begin
                        k_act = tte_pkg::ACT_SEND_ACK;
                        k_blk = r_b.block;
                    end else begin
                        k_act = tte_pkg::ACT_DONE;
                    end
                end
                tte_pkg::ACT_SEND_ERR: begin
                    k_act = tte_pkg::ACT_FAIL_INVALID;
                end
                default: begin
                    k_act = r_b.act;
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (o_load) begin
            r_o_v <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_o_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_o_data <= {2'b00, k_ec, k_len, k_blk, k_act};
            r_o_last <= k_last;
        end
    end

    assign o_m_axis_tvalid = r_o_v;
    assign o_m_axis_tdata  = r_o_data;
    assign o_m_axis_tlast  = r_o_last;

`include "tftp_transfer_engine_macros.svh"

    `TTE_ASSERT_NOW(a_rec_nonempty, i_clk, i_rst_n, r_b_v, r_b.cnt != 2'd0, "empty record held")
    `TTE_ASSERT_NOW(a_idx_range, i_clk, i_rst_n, r_b_v, r_idx < r_b.cnt, "record index overrun")
    `TTE_ASSERT_NOW(a_move_room, i_clk, i_rst_n, a_move, !r_b_v || b_pop, "record overwritten")
    `TTE_ASSERT_NEXT(a_pop_clears, i_clk, i_rst_n, b_pop && !a_move, !r_b_v, "record not released")

endmodule

`default_nettype wire

// ----- hdl/tte_session.sv -----
`default_nettype none

// Session state and per-event decision logic
module tte_session (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_ev_valid,
    input  tte_pkg::t_evt     i_ev,
    input  wire  [7:0]        i_retry_limit,
    output tte_pkg::t_rec     o_rec
);

    logic        r_active,  n_active;
    logic        r_writing, n_writing;
    logic [15:0] r_blk,     n_blk;
    logic [7:0]  r_att,     n_att;
    logic        r_final,   n_final;
    logic [9:0]  r_cur_len, n_cur_len;

    logic [9:0]  clip_len;
    logic [15:0] blk_inc;
    logic [9:0]  dlen;

    assign clip_len = (i_ev.next_len > tte_pkg::BLOCK_BYTES) ? tte_pkg::BLOCK_BYTES
                                                            : i_ev.next_len;
    assign blk_inc  = r_blk + 16'd1;
    assign dlen     = i_ev.pkt_len - tte_pkg::HEADER_BYTES;

    // Event decode
    always_comb begin
        n_active  = r_active;
        n_writing = r_writing;
        n_blk     = r_blk;
        n_att     = r_att;
        n_final   = r_final;
        n_cur_len = r_cur_len;
        o_rec     = '0;

        case (i_ev.func)
            tte_pkg::FUNC_START_READ: begin
                n_active  = 1'b1;
                n_writing = 1'b0;
                n_blk     = 16'd1;
                n_cur_len = clip_len;
                n_final   = clip_len < tte_pkg::BLOCK_BYTES;
                n_att     = 8'd1;
                o_rec     = '{act: tte_pkg::ACT_SEND_DATA, block: 16'd1, length: clip_len,
                              error_code: 1'b0, cnt: 2'd1};
            end
            tte_pkg::FUNC_START_WRITE: begin
                n_active  = 1'b1;
                n_writing = 1'b1;
                n_blk     = 16'd0;
                n_cur_len = 10'd0;
                n_final   = 1'b0;
                n_att     = 8'd1;
                o_rec     = '{act: tte_pkg::ACT_SEND_ACK, block: 16'd0, length: 10'd0,
                              error_code: 1'b0, cnt: 2'd1};
            end
            tte_pkg::FUNC_TIMEOUT: begin
                if (r_active) begin
                    if (r_att >= i_retry_limit) begin
                        n_active  = 1'b0;
                        o_rec.act = tte_pkg::ACT_FAIL_TIMEOUT;
                        o_rec.cnt = 2'd1;
                    end else begin
                        // resend current block
                        n_att       = r_att + 8'd1;
                        o_rec.act   = r_writing ? tte_pkg::ACT_SEND_ACK
                                                : tte_pkg::ACT_SEND_DATA;
                        o_rec.block = r_blk;
                        o_rec.length = r_writing ? 10'd0 : r_cur_len;
                        o_rec.cnt   = 2'd1;
                    end
                end
            end
            tte_pkg::FUNC_PACKET: begin
                if (r_active) begin
                    if (!i_ev.from_expected_peer) begin
                        o_rec.act        = tte_pkg::ACT_SEND_ERR;
                        o_rec.error_code = tte_pkg::EC_BAD_TID;
                        o_rec.cnt        = 2'd1;
                    end else if (i_ev.pkt_len < tte_pkg::HEADER_BYTES ||
                                 i_ev.pkt_len > tte_pkg::MAX_PKT_LEN) begin
                        // error then invalid fail
                        n_active         = 1'b0;
                        o_rec.act        = tte_pkg::ACT_SEND_ERR;
                        o_rec.error_code = tte_pkg::EC_INVALID;
                        o_rec.cnt        = 2'd2;
                    end else if (i_ev.opcode == tte_pkg::OP_ERROR) begin
                        n_active  = 1'b0;
                        o_rec.act = tte_pkg::ACT_FAIL_PEER;
                        o_rec.cnt = 2'd1;
                    end else if (!r_writing) begin
                        if (i_ev.opcode == tte_pkg::OP_ACK && i_ev.block_num == r_blk) begin
                            if (r_final) begin
                                n_active  = 1'b0;
                                o_rec.act = tte_pkg::ACT_DONE;
                                o_rec.cnt = 2'd1;
                            end else begin
                                n_blk        = blk_inc;
                                n_cur_len    = clip_len;
                                n_final      = clip_len < tte_pkg::BLOCK_BYTES;
                                n_att        = 8'd1;
                                o_rec.act    = tte_pkg::ACT_SEND_DATA;
                                o_rec.block  = blk_inc;
                                o_rec.length = clip_len;
                                o_rec.cnt    = 2'd1;
                            end
                        end
                    end else begin
                        if (i_ev.opcode == tte_pkg::OP_DATA && i_ev.block_num == blk_inc) begin
                            // store, ack, and done on a short block
                            n_blk        = blk_inc;
                            n_cur_len    = dlen;
                            n_att        = 8'd1;
                            o_rec.act    = tte_pkg::ACT_STORE;
                            o_rec.block  = blk_inc;
                            o_rec.length = dlen;
                            if (dlen < tte_pkg::BLOCK_BYTES) begin
                                n_active  = 1'b0;
                                o_rec.cnt = 2'd3;
                            end else begin
                                o_rec.cnt = 2'd2;
                            end
                        end
                    end
                end
            end
            default: begin
                o_rec = '0;
            end
        endcase
    end

    // Session registers, updated once per event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_writing <= 1'b0;
            r_blk     <= 16'd0;
            r_att     <= 8'd0;
            r_final   <= 1'b0;
            r_cur_len <= 10'd0;
        end else if (i_ev_valid) begin
            r_active  <= n_active;
            r_writing <= n_writing;
            r_blk     <= n_blk;
            r_att     <= n_att;
            r_final   <= n_final;
            r_cur_len <= n_cur_len;
        end
    end

endmodule

`default_nettype wire
